### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the per-token int8 quantizer.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int MAX_ROW  = 256;
    localparam int LANES    = 4;
    localparam int LANE_SH  = $clog2(LANES);
    localparam int GROUPS   = MAX_ROW / LANES;
    localparam int GA_W     = $clog2(GROUPS);
    localparam int LEN_W    = 9;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 32;
    localparam int MAG_W    = 31;
    localparam int NUM_W    = 38;
    localparam int QBITS    = 7;
    localparam int CODE_W   = 8;
    localparam int SCALE_W  = 25;
    localparam int QCNT_W   = 3;
    localparam int SC_REM_W = 7;
    localparam logic [7:0] DIV127 = 8'd127;

    // floor(x/127) = (x * RECIP127) >> RECIP_SH, exact for any 31-bit x
    localparam logic [31:0] RECIP127 = 32'd2164392969;
    localparam int          RECIP_SH = 38;

    typedef enum logic [2:0] {
        S_FILL,
        S_SCALE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_PUT
    } state_t;

    // lane divider controls
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

endpackage

### rtl/spq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/spq_lane_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_lane_div
// Bit-serial divider for one lane: round-half-even(|p|*127/amax), signed code.
// ----------------------------------------------------------------------------
module spq_lane_div (
    input  logic                                 aclk,
    input  spq_pkg::lane_ctl_t                   ctl,
    input  logic signed [spq_pkg::PROD_W-1:0]    prod,
    input  logic [spq_pkg::MAG_W-1:0]            den,
    input  logic                                 lane_ok,
    output logic signed [spq_pkg::CODE_W-1:0]    code
);

    localparam int NUM_W = spq_pkg::NUM_W;

    logic [spq_pkg::NUM_W-1:0]  rem_reg, rem_next;
    logic [spq_pkg::NUM_W-1:0]  den_sh_reg, den_sh_next;
    logic [spq_pkg::QBITS-1:0]  q_reg, q_next;
    logic [spq_pkg::MAG_W-1:0]  den_reg;
    logic                       neg_reg, ok_reg, zero_reg;
    logic [spq_pkg::PROD_W-1:0] mag;
    logic [spq_pkg::PROD_W:0]   two_r;
    logic                       up;
    logic [spq_pkg::CODE_W-1:0] q_rnd;
    logic [spq_pkg::CODE_W-1:0] q_sat;

    assign mag = prod[spq_pkg::PROD_W-1] ? (~prod + 1'b1) : prod;

    // load the numerator or retire one quotient bit
    always_comb begin
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        q_next      = q_reg;
        if (ctl.load) begin
            rem_next    = NUM_W'(mag) * NUM_W'(spq_pkg::DIV127);
            den_sh_next = NUM_W'(den) << (spq_pkg::QBITS - 1);
            q_next      = '0;
        end else if (ctl.step) begin
            if (rem_reg >= den_sh_reg) begin
                rem_next = rem_reg - den_sh_reg;
                q_next   = {q_reg[spq_pkg::QBITS-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[spq_pkg::QBITS-2:0], 1'b0};
            end
            den_sh_next = den_sh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        q_reg      <= q_next;
        if (ctl.load) begin
            neg_reg  <= prod[spq_pkg::PROD_W-1];
            ok_reg   <= lane_ok;
            zero_reg <= (den == '0);
            den_reg  <= den;
        end
    end

    // round half to even against the full divisor, clamp, apply sign
    always_comb begin
        two_r = {rem_reg[spq_pkg::PROD_W-1:0], 1'b0};
        up    = (two_r > (spq_pkg::PROD_W+1)'(den_reg))
             || ((two_r == (spq_pkg::PROD_W+1)'(den_reg)) && q_reg[0]);
        q_rnd = spq_pkg::CODE_W'(q_reg) + spq_pkg::CODE_W'(up);
        q_sat = (q_rnd > spq_pkg::CODE_W'(127)) ? spq_pkg::CODE_W'(127) : q_rnd;
        if (!ok_reg || zero_reg) begin
            code = '0;
        end else begin
            code = neg_reg ? $signed(~q_sat + 1'b1) : $signed(q_sat);
        end
    end

endmodule

### rtl/smoothed_per_token_int8_quantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_per_token_int8_quantizer_core
// Per-token symmetric int8 quantizer of smoothed activations.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid/s_ready, s_*_lane0..3  | one word: four value/factor pairs
//  output   | m_valid/m_ready, m_*           | one word: four codes, scale, last
//  config   | cfg_wr_en, cfg_wr_data         | row_length, no wait
//
// Fill: one input word per cycle; products go to the group RAM.
// Emission: the row scale is formed once per row (reciprocal multiply),
// then each group passes through RAM read, divider load, 7 divider steps and
// output load.
// Reset leaves row_length at 256 and an empty row; the RAM needs no clearing.
// A stalled output word holds in the output register; the next group waits.
// ----------------------------------------------------------------------------
module smoothed_per_token_int8_quantizer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_value_lane0,
    input  logic signed [15:0]  s_value_lane1,
    input  logic signed [15:0]  s_value_lane2,
    input  logic signed [15:0]  s_value_lane3,
    input  logic [15:0]         s_smooth_lane0,
    input  logic [15:0]         s_smooth_lane1,
    input  logic [15:0]         s_smooth_lane2,
    input  logic [15:0]         s_smooth_lane3,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [7:0]   m_quant_lane0,
    output logic signed [7:0]   m_quant_lane1,
    output logic signed [7:0]   m_quant_lane2,
    output logic signed [7:0]   m_quant_lane3,
    output logic [24:0]         m_row_scale,
    output logic                m_last_group
);

    localparam int LANES  = spq_pkg::LANES;
    localparam int PROD_W = spq_pkg::PROD_W;
    localparam int MAG_W  = spq_pkg::MAG_W;
    localparam int LEN_W  = spq_pkg::LEN_W;
    localparam int GA_W   = spq_pkg::GA_W;

    spq_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0]             row_len_reg;
    logic [LEN_W-1:0]             len_eff;
    logic [LEN_W-1:0]             count_reg, count_next;
    logic [MAG_W-1:0]             peak_reg, peak_next;
    logic [GA_W-1:0]              gidx_reg, gidx_next;
    logic [GA_W-1:0]              last_g;
    logic [spq_pkg::QCNT_W-1:0]   qcnt_reg;
    logic [MAG_W-1:0]             sc_num_reg;
    logic [MAG_W-1:0]             sc_q_reg;
    logic [2*PROD_W-1:0]          sc_prod;
    logic [MAG_W-1:0]             sc_back;
    logic [spq_pkg::SC_REM_W-1:0] sc_rem;
    logic [spq_pkg::SCALE_W-1:0]  scale_reg;
    logic                         s_take, m_free, row_done;
    logic                         q_done, put;
    spq_pkg::lane_ctl_t           lane_ctl;

    logic signed [15:0]           vals   [LANES];
    logic [15:0]                  smooth [LANES];
    logic signed [PROD_W-1:0]     prods  [LANES];
    logic signed [PROD_W-1:0]     rd_prod[LANES];
    logic signed [7:0]            codes  [LANES];
    logic                         lane_ok[LANES];
    logic [LANES*PROD_W-1:0]      wdata, rdata;
    logic signed [7:0]            q_out_reg [LANES];
    logic [spq_pkg::SCALE_W-1:0]  scale_out_reg;
    logic                         last_out_reg, m_valid_reg;

    assign vals[0]   = s_value_lane0;
    assign vals[1]   = s_value_lane1;
    assign vals[2]   = s_value_lane2;
    assign vals[3]   = s_value_lane3;
    assign smooth[0] = s_smooth_lane0;
    assign smooth[1] = s_smooth_lane1;
    assign smooth[2] = s_smooth_lane2;
    assign smooth[3] = s_smooth_lane3;

    // clamp the row length to 1..MAX_ROW
    always_comb begin
        if (row_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(row_len_reg) > spq_pkg::MAX_ROW) begin
            len_eff = LEN_W'(spq_pkg::MAX_ROW);
        end else begin
            len_eff = row_len_reg;
        end
    end

    assign last_g = GA_W'((len_eff - 1'b1) >> spq_pkg::LANE_SH);

    // form products and the running peak of the taken lanes
    always_comb begin
        peak_next = peak_reg;
        for (int j = 0; j < LANES; j++) begin
            logic [PROD_W-1:0] m;
            prods[j] = PROD_W'($signed(vals[j]) * $signed({1'b0, smooth[j]}));
            m = prods[j][PROD_W-1] ? (~prods[j] + 1'b1) : prods[j];
            if (((LEN_W+1)'(count_reg) + (LEN_W+1)'(j) < (LEN_W+1)'(len_eff))
                && (MAG_W'(m) > peak_next)) begin
                peak_next = MAG_W'(m);
            end
            wdata[j*PROD_W +: PROD_W] = prods[j];
        end
    end

    assign s_ready  = (state_reg == spq_pkg::S_FILL);
    assign s_take   = s_valid && s_ready;
    assign row_done = ((LEN_W+1)'(count_reg) + (LEN_W+1)'(LANES)) >= (LEN_W+1)'(len_eff);
    assign m_free   = !m_valid_reg || m_ready;
    assign q_done   = (qcnt_reg == spq_pkg::QCNT_W'(spq_pkg::QBITS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_FILL:  if (s_take && row_done) state_next = spq_pkg::S_SCALE;
            spq_pkg::S_SCALE: state_next = spq_pkg::S_READ;
            spq_pkg::S_READ:  state_next = spq_pkg::S_LOAD;
            spq_pkg::S_LOAD:  state_next = spq_pkg::S_DIV;
            spq_pkg::S_DIV:   if (q_done) state_next = spq_pkg::S_PUT;
            spq_pkg::S_PUT: begin
                if (m_free) begin
                    state_next = (gidx_reg == last_g) ? spq_pkg::S_FILL
                                                      : spq_pkg::S_READ;
                end
            end
            default: state_next = spq_pkg::S_FILL;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        lane_ctl   = '0;
        put        = 1'b0;
        count_next = count_reg;
        gidx_next  = gidx_reg;
        unique case (state_reg)
            spq_pkg::S_FILL: begin
                if (s_take) count_next = count_reg + LEN_W'(LANES);
            end
            spq_pkg::S_LOAD: lane_ctl.load = 1'b1;
            spq_pkg::S_DIV:  lane_ctl.step = 1'b1;
            spq_pkg::S_PUT: begin
                put = m_free;
                if (m_free) gidx_next = (gidx_reg == last_g) ? '0 : gidx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::S_FILL;
            row_len_reg <= LEN_W'(spq_pkg::MAX_ROW);
            count_reg   <= '0;
            peak_reg    <= '0;
            gidx_reg    <= '0;
            qcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            gidx_reg  <= gidx_next;
            if (cfg_wr_en) begin
                row_len_reg <= cfg_wr_data;
                count_reg   <= '0;
                peak_reg    <= '0;
            end else if (put && (gidx_reg == last_g)) begin
                count_reg <= '0;
                peak_reg  <= '0;
            end else if (s_take) begin
                count_reg <= count_next;
                peak_reg  <= peak_next;
            end
            qcnt_reg <= (state_reg == spq_pkg::S_DIV) ? qcnt_reg + 1'b1 : '0;
            if (put) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // divide the peak by 127 with a reciprocal multiply, round from the remainder
    assign sc_prod = {{(2*PROD_W-MAG_W){1'b0}}, sc_num_reg}
                   * {{PROD_W{1'b0}}, spq_pkg::RECIP127};
    assign sc_back = (sc_q_reg << spq_pkg::QBITS) - sc_q_reg;
    assign sc_rem  = spq_pkg::SC_REM_W'(sc_num_reg - sc_back);

    always_ff @(posedge aclk) begin
        if (s_take && row_done) begin
            sc_num_reg <= peak_next;
        end
        if (state_reg == spq_pkg::S_SCALE) begin
            sc_q_reg <= MAG_W'(sc_prod >> spq_pkg::RECIP_SH);
        end
        if (state_reg == spq_pkg::S_READ && gidx_reg == '0) begin
            scale_reg <= spq_pkg::SCALE_W'(sc_q_reg)
                       + spq_pkg::SCALE_W'(sc_rem >= spq_pkg::SC_REM_W'(64));
        end
    end

    // group store: written during fill, read back during emission
    spq_ram #(
        .WIDTH(LANES * PROD_W),
        .DEPTH(spq_pkg::GROUPS)
    ) u_store (
        .aclk  (aclk),
        .we    (s_take),
        .waddr (GA_W'(count_reg >> spq_pkg::LANE_SH)),
        .wdata (wdata),
        .raddr (gidx_reg),
        .rdata (rdata)
    );

    // one divider per lane
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        assign rd_prod[j] = rdata[j*PROD_W +: PROD_W];
        assign lane_ok[j] = (LEN_W'({gidx_reg, spq_pkg::LANE_SH'(j)}) < len_eff);
        spq_lane_div u_div (
            .aclk    (aclk),
            .ctl     (lane_ctl),
            .prod    (rd_prod[j]),
            .den     (peak_reg),
            .lane_ok (lane_ok[j]),
            .code    (codes[j])
        );
    end

    // load the output word
    always_ff @(posedge aclk) begin
        if (put) begin
            for (int j = 0; j < LANES; j++) begin
                q_out_reg[j] <= codes[j];
            end
            scale_out_reg <= scale_reg;
            last_out_reg  <= (gidx_reg == last_g);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_quant_lane0 = q_out_reg[0];
    assign m_quant_lane1 = q_out_reg[1];
    assign m_quant_lane2 = q_out_reg[2];
    assign m_quant_lane3 = q_out_reg[3];
    assign m_row_scale   = scale_out_reg;
    assign m_last_group  = last_out_reg;

endmodule

### rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the quantizer core, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [7:0] m_quant_lane0,
    input logic signed [7:0] m_quant_lane1,
    input logic signed [7:0] m_quant_lane2,
    input logic signed [7:0] m_quant_lane3,
    input logic [24:0]       m_row_scale,
    input logic              m_last_group
);

    // no output word right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // a stalled word holds its valid, scale and last flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_scale) && $stable(m_last_group))
        else $error("stalled output word changed");

    // codes never reach -128
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quant_lane0 != -8'sd128) && (m_quant_lane1 != -8'sd128)
                 && (m_quant_lane2 != -8'sd128) && (m_quant_lane3 != -8'sd128))
        else $error("code out of range");

    // no input taken in the middle of a row's emission
    a_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_group |-> !s_ready)
        else $error("input accepted during emission");

endmodule

bind smoothed_per_token_int8_quantizer_core spq_checker u_spq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_quant_lane0 (m_quant_lane0),
    .m_quant_lane1 (m_quant_lane1),
    .m_quant_lane2 (m_quant_lane2),
    .m_quant_lane3 (m_quant_lane3),
    .m_row_scale   (m_row_scale),
    .m_last_group  (m_last_group)
);

### test/tb_smoothed_per_token_int8_quantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_per_token_int8_quantizer_core
// Self-checking bench of the per-token int8 quantizer. A directed table of
// rows and then random rows are driven over the input channel. A local
// model of the row store, the peak and the rounding predicts every output
// word, and each accepted word is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_smoothed_per_token_int8_quantizer_core;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [7:0] q0;
        logic signed [7:0] q1;
        logic signed [7:0] q2;
        logic signed [7:0] q3;
        logic [24:0]       scale;
        logic              last;
    } quant_word_t;

    typedef struct {
        logic signed [15:0] v [4];
        logic [15:0]        s [4];
    } lane_word_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [8:0]         cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_value_lane0, s_value_lane1, s_value_lane2, s_value_lane3;
    logic [15:0]        s_smooth_lane0, s_smooth_lane1, s_smooth_lane2, s_smooth_lane3;
    logic               m_valid;
    logic               m_ready;
    logic signed [7:0]  m_quant_lane0, m_quant_lane1, m_quant_lane2, m_quant_lane3;
    logic [24:0]        m_row_scale;
    logic               m_last_group;

    // model state
    logic signed [31:0] prod_mem [spq_pkg::MAX_ROW];
    logic [30:0]        peak_mag;
    int unsigned        elem_cnt;
    logic [8:0]         len_reg;

    quant_word_t        pending_q [$];
    int                 errors;
    int                 idle_cnt;
    bit                 calm;
    bit                 fired;

    smoothed_per_token_int8_quantizer_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_lane0(s_value_lane0), .s_value_lane1(s_value_lane1),
        .s_value_lane2(s_value_lane2), .s_value_lane3(s_value_lane3),
        .s_smooth_lane0(s_smooth_lane0), .s_smooth_lane1(s_smooth_lane1),
        .s_smooth_lane2(s_smooth_lane2), .s_smooth_lane3(s_smooth_lane3),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quant_lane0(m_quant_lane0), .m_quant_lane1(m_quant_lane1),
        .m_quant_lane2(m_quant_lane2), .m_quant_lane3(m_quant_lane3),
        .m_row_scale(m_row_scale), .m_last_group(m_last_group)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned eff_len();
        int unsigned n;
        n = len_reg;
        if (n < 1) n = 1;
        if (n > spq_pkg::MAX_ROW) n = spq_pkg::MAX_ROW;
        return n;
    endfunction

    // round-half-even code of one product against the row peak
    function automatic logic signed [7:0] code_of(logic signed [31:0] p, logic [30:0] amax);
        longint unsigned mag, num, q, r;
        if (amax == 0) return 8'sd0;
        mag = (p < 0) ? longint'(-longint'(p)) : longint'(p);
        num = mag * 127;
        q = num / amax;
        r = num % amax;
        if (2 * r > amax || (2 * r == amax && q[0])) q++;
        if (q > 127) q = 127;
        return (p < 0) ? -8'(q) : 8'(q);
    endfunction

    function automatic void write_len(logic [8:0] v);
        len_reg  = v;
        elem_cnt = 0;
        peak_mag = '0;
    endfunction

    // take one word into the row model; queue the row's words when complete
    function automatic void predict_word(lane_word_t w);
        int unsigned len, groups, sc, idx;
        longint p;
        longint unsigned mag;
        quant_word_t e;
        logic signed [7:0] c [4];
        len = eff_len();
        if (elem_cnt >= len) begin
            elem_cnt = 0;
            peak_mag = '0;
        end
        for (int j = 0; j < 4 && elem_cnt < len; j++) begin
            p = longint'(w.v[j]) * longint'({1'b0, w.s[j]});
            mag = (p < 0) ? -p : p;
            prod_mem[elem_cnt] = 32'(p);
            if (mag > peak_mag) peak_mag = 31'(mag);
            elem_cnt++;
        end
        if (elem_cnt < len) return;
        groups = (len + 3) / 4;
        sc = peak_mag / 127 + ((2 * (peak_mag % 127) > 127) ? 1 : 0);
        for (int g = 0; g < groups; g++) begin
            for (int j = 0; j < 4; j++) begin
                idx = g * 4 + j;
                c[j] = (idx < len) ? code_of(prod_mem[idx], peak_mag) : 8'sd0;
            end
            e.q0 = c[0]; e.q1 = c[1]; e.q2 = c[2]; e.q3 = c[3];
            e.scale = 25'(sc);
            e.last = (g + 1 == groups);
            pending_q.push_back(e);
        end
        elem_cnt = 0;
        peak_mag = '0;
    endfunction

    // compare each accepted output word with the oldest prediction
    always @(posedge aclk) begin
        quant_word_t got, exp_w;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_quant_lane0, m_quant_lane1, m_quant_lane2, m_quant_lane3,
                    m_row_scale, m_last_group};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, got);
                errors++;
            end else begin
                exp_w = pending_q.pop_front();
                if (got !== exp_w) begin
                    $display("%0t: mismatch expected q=%0d %0d %0d %0d scale=%0d last=%0b",
                             $time, exp_w.q0, exp_w.q1, exp_w.q2, exp_w.q3,
                             exp_w.scale, exp_w.last);
                    $display("%0t:          actual   q=%0d %0d %0d %0d scale=%0d last=%0b",
                             $time, got.q0, got.q1, got.q2, got.q3, got.scale, got.last);
                    errors++;
                end
            end
        end
    end

    // random receiver stalls in bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
        end else if (m_ready && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            idle_cnt = $urandom_range(1, 4);
        end else if (!m_ready) begin
            idle_cnt--;
            if (idle_cnt <= 0) m_ready <= 1'b1;
        end
    end

    // watchdog on accepted words
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("smoothed_per_token_int8_quantizer_core test failed");
                $finish;
            end
        end
    end

    // drive one word and hold it until taken; valid stays up afterwards unless the next word draws a gap
    task automatic send_word(lane_word_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value_lane0 <= w.v[0]; s_value_lane1 <= w.v[1];
        s_value_lane2 <= w.v[2]; s_value_lane3 <= w.v[3];
        s_smooth_lane0 <= w.s[0]; s_smooth_lane1 <= w.s[1];
        s_smooth_lane2 <= w.s[2]; s_smooth_lane3 <= w.s[3];
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
    endtask

    // drop valid, wait for all words, let the block settle, then write the register
    task automatic set_len(logic [8:0] v);
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        write_len(v);
    endtask

    function automatic lane_word_t rand_word(int mode);
        lane_word_t w;
        for (int j = 0; j < 4; j++) begin
            case (mode)
                0: begin w.v[j] = 16'($urandom); w.s[j] = 16'($urandom); end
                1: begin w.v[j] = 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
                         w.s[j] = 16'hffff; end
                2: begin w.v[j] = 16'($signed($urandom_range(0, 64)) - 32);
                         w.s[j] = 16'($urandom_range(0, 8192)); end
                default: begin w.v[j] = 16'sd0; w.s[j] = 16'($urandom); end
            endcase
        end
        return w;
    endfunction

    // directed table: row length and word pattern (mode) per row
    typedef struct { logic [8:0] len; int mode; int words; } row_case_t;
    row_case_t dir_tab [9] = '{
        '{9'd4,   3, 1},   // zero row peak
        '{9'd4,   1, 1},   // extreme values
        '{9'd1,   0, 1},   // lanes past the row
        '{9'd0,   0, 2},   // length zero acts as one
        '{9'd7,   2, 2},
        '{9'd5,   0, 2},
        '{9'd3,   2, 1},
        '{9'd8,   0, 2},
        '{9'd2,   1, 1}
    };

    initial begin
        lane_word_t w;
        int words;
        quant_word_t e;
        errors = 0; calm = 0; idle_cnt = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; s_valid = 1'b0;
        {s_value_lane0, s_value_lane1, s_value_lane2, s_value_lane3} = '0;
        {s_smooth_lane0, s_smooth_lane1, s_smooth_lane2, s_smooth_lane3} = '0;
        len_reg = 9'd256; elem_cnt = 0; peak_mag = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first row at reset length 256, one word of extremes at the end
        for (int i = 0; i < 64; i++) send_word(rand_word(i == 63 ? 1 : 2));

        // fixed result after a single zero word with length 1
        set_len(9'd1);
        w = rand_word(3);
        send_word(w);
        s_valid <= 1'b0;
        e = '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 25'd0, 1'b1};
        if (pending_q.size() == 0) begin
            $display("%0t: mismatch expected %h actual none", $time, e);
            errors++;
        end else if (pending_q[0] !== e) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, pending_q[0]);
            errors++;
        end
        while (pending_q.size() != 0) @(posedge aclk);

        for (int r = 0; r < 9; r++) begin
            set_len(dir_tab[r].len);
            for (int i = 0; i < dir_tab[r].words; i++) send_word(rand_word(dir_tab[r].mode));
        end

        // partial row dropped by a register write
        set_len(9'd12);
        send_word(rand_word(0));
        set_len(9'd511);   // above the row size, acts as 256
        for (int i = 0; i < 64; i++) send_word(rand_word(0));

        // random rows, mostly short
        words = 0;
        while (words < 290) begin
            logic [8:0] l;
            int n;
            l = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) :
                                               9'($urandom_range(1, 24));
            if (words > 240) calm = 1;
            set_len(l);
            n = (eff_len() + 3) / 4 * $urandom_range(1, 2);
            for (int i = 0; i < n; i++) begin
                send_word(rand_word($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3)));
                words++;
            end
        end

        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("smoothed_per_token_int8_quantizer_core test passed");
        end else begin
            $display("smoothed_per_token_int8_quantizer_core test failed");
        end
        $finish;
    end

endmodule
